/* src/priority_run_queue_manager_core_macros.svh */
// Assertion helpers shared by the checking code of the run queue core.
`ifndef PRIORITY_RUN_QUEUE_MANAGER_CORE_MACROS_SVH
`define PRIORITY_RUN_QUEUE_MANAGER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("run queue check failed");

// Next-cycle implication, masked during reset.
`define PRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("run queue check failed");

`endif

/* src/prq_pkg.sv */
`timescale 1ns / 1ps

package prq_pkg;

    localparam int NUM_QUEUES_DEF = 32;
    localparam int NUM_SLOTS_DEF  = 64;

    localparam int CMD_W      = 1;
    localparam int SLOT_IN_W  = 6;
    localparam int PRIO_W     = 7;
    localparam int PRIO_SHIFT = 2;
    localparam int STATUS_W   = 2;
    localparam int MASK_OUT_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd3;

endpackage

/* src/prq_slot_ram.sv */
`timescale 1ns / 1ps

module prq_slot_ram #(
    parameter  int DEPTH = 64,
    parameter  int WIDTH = 6,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/priority_run_queue_manager_core.sv */
`timescale 1ns / 1ps
// Multilevel priority run queue manager.
// Request channel (s_valid/s_ready): s_cmd selects insert at the tail of a
// queue or remove of a process slot; s_proc_slot names the slot and
// s_priority_req >> 2 picks one of NUM_QUEUES FIFO queues (saturated).
// Result channel (m_valid/m_ready): m_status (ok, already queued, queue
// empty, not queued) and m_queue_mask, the non-empty summary after the request.
// Flow: an accepted request is held in the stage register while it executes,
// and its result is then registered and presented from the output register.
// Throughput: one request per cycle while m_ready is high; the per-slot link
// RAMs are read at acceptance and the queue head/tail registers and the
// summary mask are updated when the request executes, with a write bypass
// covering the RAM read that overlaps the previous request's update.
// Reset (aresetn low, synchronous): both pipeline stages empty, summary
// mask and queued flags clear. No clearing pass is needed.
// Stall: while m_ready is low the result is held; one further request is
// taken into the stage register, then s_ready drops until the result goes.
module priority_run_queue_manager_core #(
    parameter int NUM_QUEUES = prq_pkg::NUM_QUEUES_DEF,
    parameter int NUM_SLOTS  = prq_pkg::NUM_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prq_pkg::CMD_W-1:0]     s_cmd,
    input  logic [prq_pkg::SLOT_IN_W-1:0] s_proc_slot,
    input  logic [prq_pkg::PRIO_W-1:0]    s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prq_pkg::STATUS_W-1:0]  m_status,
    output logic [prq_pkg::MASK_OUT_W-1:0] m_queue_mask
);

    import prq_pkg::*;

`include "priority_run_queue_manager_core_macros.svh"

    localparam int SW        = $clog2(NUM_SLOTS);
    localparam int QW        = $clog2(NUM_QUEUES);
    localparam int MW        = (NUM_QUEUES > MASK_OUT_W) ? NUM_QUEUES : MASK_OUT_W;
    localparam int SLOT_IN_N = 1 << SLOT_IN_W;
    localparam int PQ_W      = PRIO_W - PRIO_SHIFT;

    // input mapping
    logic [SW-1:0]   slot_map [SLOT_IN_N];
    logic [SW-1:0]   in_slot;
    logic [PQ_W-1:0] in_prio_q;
    logic [QW-1:0]   in_q;
    logic            in_take;

    for (genvar i = 0; i < SLOT_IN_N; i++) begin : g_slot_map
        assign slot_map[i] = SW'(i % NUM_SLOTS);
    end

    assign in_slot   = slot_map[s_proc_slot];
    assign in_prio_q = s_priority_req[PRIO_W-1:PRIO_SHIFT];
    assign in_q      = (PRIO_W'(in_prio_q) >= PRIO_W'(NUM_QUEUES)) ?
                       QW'(NUM_QUEUES - 1) : QW'(in_prio_q);

    // pipeline registers
    logic                stg_valid_reg;
    logic [CMD_W-1:0]    stg_cmd_reg;
    logic [SW-1:0]       stg_slot_reg;
    logic [QW-1:0]       stg_q_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [MASK_OUT_W-1:0] out_mask_reg;
    logic                fire;

    assign fire    = stg_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || fire;
    assign in_take = s_valid && s_ready;

    // queue state
    logic [NUM_QUEUES-1:0] mask_reg;
    logic [NUM_QUEUES-1:0] mask_next;
    logic [NUM_SLOTS-1:0]  queued_reg;
    logic [SW-1:0]         first_reg [NUM_QUEUES];
    logic [SW-1:0]         last_reg  [NUM_QUEUES];

    // per-slot link RAMs
    logic          nxt_we, prv_we, qix_we;
    logic [SW-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, qix_waddr;
    logic [QW-1:0] qix_wdata;
    logic [SW-1:0] nxt_rdata, prv_rdata;
    logic [QW-1:0] qix_rdata;

    prq_slot_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_next_ram (
        .aclk(aclk), .we(nxt_we && fire), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(in_take), .raddr(in_slot), .rdata(nxt_rdata)
    );

    prq_slot_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_prev_ram (
        .aclk(aclk), .we(prv_we && fire), .waddr(prv_waddr), .wdata(prv_wdata),
        .re(in_take), .raddr(in_slot), .rdata(prv_rdata)
    );

    prq_slot_ram #(.DEPTH(NUM_SLOTS), .WIDTH(QW)) u_qidx_ram (
        .aclk(aclk), .we(qix_we && fire), .waddr(qix_waddr), .wdata(qix_wdata),
        .re(in_take), .raddr(in_slot), .rdata(qix_rdata)
    );

    // bypass of the last committed RAM writes
    logic          byp_nxt_vld_reg, byp_prv_vld_reg, byp_qix_vld_reg;
    logic [SW-1:0] byp_nxt_addr_reg, byp_nxt_data_reg;
    logic [SW-1:0] byp_prv_addr_reg, byp_prv_data_reg;
    logic [SW-1:0] byp_qix_addr_reg;
    logic [QW-1:0] byp_qix_data_reg;
    logic [SW-1:0] nxt_s, prv_s;
    logic [QW-1:0] qr;

    assign nxt_s = (byp_nxt_vld_reg && byp_nxt_addr_reg == stg_slot_reg) ?
                   byp_nxt_data_reg : nxt_rdata;
    assign prv_s = (byp_prv_vld_reg && byp_prv_addr_reg == stg_slot_reg) ?
                   byp_prv_data_reg : prv_rdata;
    assign qr    = (byp_qix_vld_reg && byp_qix_addr_reg == stg_slot_reg) ?
                   byp_qix_data_reg : qix_rdata;

    // execute
    logic [STATUS_W-1:0] status_c;
    logic                first_we, last_we, queued_set, queued_clr;
    logic [QW-1:0]       first_waddr, last_waddr;
    logic [SW-1:0]       first_wdata, last_wdata;
    logic                is_head, is_tail;
    logic [MW-1:0]       mask_wide;

    assign is_head = first_reg[qr] == stg_slot_reg;
    assign is_tail = last_reg[qr] == stg_slot_reg;

    always_comb begin
        status_c    = ST_OK;
        mask_next   = mask_reg;
        first_we    = 1'b0;
        first_waddr = stg_q_reg;
        first_wdata = stg_slot_reg;
        last_we     = 1'b0;
        last_waddr  = stg_q_reg;
        last_wdata  = stg_slot_reg;
        nxt_we      = 1'b0;
        nxt_waddr   = last_reg[stg_q_reg];
        nxt_wdata   = stg_slot_reg;
        prv_we      = 1'b0;
        prv_waddr   = stg_slot_reg;
        prv_wdata   = last_reg[stg_q_reg];
        qix_we      = 1'b0;
        qix_waddr   = stg_slot_reg;
        qix_wdata   = stg_q_reg;
        queued_set  = 1'b0;
        queued_clr  = 1'b0;
        if (stg_cmd_reg == CMD_INSERT) begin
            if (queued_reg[stg_slot_reg]) begin
                status_c = ST_QUEUED;
            end else begin
                if (!mask_reg[stg_q_reg]) begin
                    first_we             = 1'b1;
                    mask_next[stg_q_reg] = 1'b1;
                end else begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
                last_we    = 1'b1;
                qix_we     = 1'b1;
                queued_set = 1'b1;
            end
        end else begin
            priority if (!mask_reg[stg_q_reg]) begin
                status_c = ST_EMPTY;
            end else if (!queued_reg[stg_slot_reg]) begin
                status_c = ST_NOT_QUEUED;
            end else begin
                queued_clr = 1'b1;
                priority if (is_head && is_tail) begin
                    mask_next[qr] = 1'b0;
                end else if (is_head) begin
                    first_we    = 1'b1;
                    first_waddr = qr;
                    first_wdata = nxt_s;
                end else if (is_tail) begin
                    last_we    = 1'b1;
                    last_waddr = qr;
                    last_wdata = prv_s;
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_s;
                    nxt_wdata = nxt_s;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_s;
                    prv_wdata = prv_s;
                end
            end
        end
    end

    assign mask_wide = MW'(mask_next);

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            mask_reg        <= '0;
            queued_reg      <= '0;
            byp_nxt_vld_reg <= 1'b0;
            byp_prv_vld_reg <= 1'b0;
            byp_qix_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                stg_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (fire) begin
                mask_reg <= mask_next;
                if (queued_set) begin
                    queued_reg[stg_slot_reg] <= 1'b1;
                end
                if (queued_clr) begin
                    queued_reg[stg_slot_reg] <= 1'b0;
                end
                if (nxt_we) begin
                    byp_nxt_vld_reg <= 1'b1;
                end
                if (prv_we) begin
                    byp_prv_vld_reg <= 1'b1;
                end
                if (qix_we) begin
                    byp_qix_vld_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            stg_cmd_reg  <= s_cmd;
            stg_slot_reg <= in_slot;
            stg_q_reg    <= in_q;
        end
        if (fire) begin
            out_status_reg <= status_c;
            out_mask_reg   <= mask_wide[MASK_OUT_W-1:0];
            if (first_we) begin
                first_reg[first_waddr] <= first_wdata;
            end
            if (last_we) begin
                last_reg[last_waddr] <= last_wdata;
            end
            if (nxt_we) begin
                byp_nxt_addr_reg <= nxt_waddr;
                byp_nxt_data_reg <= nxt_wdata;
            end
            if (prv_we) begin
                byp_prv_addr_reg <= prv_waddr;
                byp_prv_data_reg <= prv_wdata;
            end
            if (qix_we) begin
                byp_qix_addr_reg <= qix_waddr;
                byp_qix_data_reg <= qix_wdata;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_queue_mask = out_mask_reg;

    // checks
    `PRQ_ASSERT_NEXT(a_insert_sets_bit, aclk, aresetn,
        fire && stg_cmd_reg == CMD_INSERT && status_c == ST_OK, mask_reg[$past(stg_q_reg)])
    `PRQ_ASSERT_NEXT(a_empty_keeps_mask, aclk, aresetn,
        fire && status_c == ST_EMPTY, $stable(mask_reg))
    `PRQ_ASSERT_NEXT(a_remove_clears_slot, aclk, aresetn,
        fire && stg_cmd_reg == CMD_REMOVE && status_c == ST_OK,
        !queued_reg[$past(stg_slot_reg)])
    `PRQ_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn,
        !s_ready, stg_valid_reg && out_valid_reg && !m_ready)

endmodule
